>>> design/dmfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmfs_pkg;

    localparam int VALUE_W         = 8;
    localparam int POS_W           = 3;
    localparam int GLYPH_COLS      = 5;
    localparam int GLYPH_ROWS      = 7;
    localparam int COL_W           = 8;
    localparam int PAT_W           = GLYPH_COLS * GLYPH_ROWS;
    localparam int CTRL_BITS       = VALUE_W;
    localparam int CNT_W           = $clog2(PAT_W);
    localparam int CHARS_PER_FRAME_DEF = 8;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_CTRL = 1'b1;

    typedef logic [PAT_W-1:0]              t_pattern;
    typedef logic [GLYPH_COLS*COL_W-1:0]   t_glyph;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic [POS_W-1:0]              t_pos;

    // Font columns packed with column 0 in the top byte and column 4 in the bottom byte.
    function automatic t_glyph font_glyph(input logic [6:0] code);
        t_glyph g;
        case (code)
            7'd33:  g = 40'h00_00_7b_00_00;
            7'd34:  g = 40'h00_70_00_70_00;
            7'd35:  g = 40'h14_7f_14_7f_14;
            7'd36:  g = 40'h24_2a_7f_2a_12;
            7'd37:  g = 40'h23_13_08_64_62;
            7'd38:  g = 40'h05_22_55_49_36;
            7'd39:  g = 40'h00_00_60_50_00;
            7'd40:  g = 40'h00_41_22_1c_00;
            7'd41:  g = 40'h00_1c_22_41_00;
            7'd42:  g = 40'h14_08_3e_08_14;
            7'd43:  g = 40'h08_08_3e_08_08;
            7'd44:  g = 40'h00_00_06_05_00;
            7'd45:  g = 40'h08_08_08_08_08;
            7'd46:  g = 40'h00_00_03_03_00;
            7'd47:  g = 40'h20_10_08_04_02;
            7'd48:  g = 40'h3e_51_49_45_3e;
            7'd49:  g = 40'h00_01_7f_21_00;
            7'd50:  g = 40'h31_49_45_43_21;
            7'd51:  g = 40'h46_69_51_41_42;
            7'd52:  g = 40'h04_7f_24_14_0c;
            7'd53:  g = 40'h4e_51_51_51_72;
            7'd54:  g = 40'h06_49_49_29_1e;
            7'd55:  g = 40'h70_48_47_40_40;
            7'd56:  g = 40'h36_49_49_49_36;
            7'd57:  g = 40'h3c_4a_49_49_30;
            7'd58:  g = 40'h00_00_36_36_00;
            7'd59:  g = 40'h00_00_36_35_00;
            7'd60:  g = 40'h00_41_22_14_08;
            7'd61:  g = 40'h14_14_14_14_14;
            7'd62:  g = 40'h08_14_22_41_00;
            7'd63:  g = 40'h30_48_44_45_20;
            7'd64:  g = 40'h32_49_79_41_3e;
            7'd65:  g = 40'h3f_44_44_44_3f;
            7'd66:  g = 40'h36_49_49_49_7f;
            7'd67:  g = 40'h22_41_41_41_3e;
            7'd68:  g = 40'h1c_22_41_41_7f;
            7'd69:  g = 40'h41_49_49_49_7f;
            7'd70:  g = 40'h40_48_48_48_7f;
            7'd71:  g = 40'h2f_49_49_41_3e;
            7'd72:  g = 40'h7f_08_08_08_7f;
            7'd73:  g = 40'h00_41_7f_41_00;
            7'd74:  g = 40'h40_7e_41_01_02;
            7'd75:  g = 40'h41_22_14_08_7f;
            7'd76:  g = 40'h01_01_01_01_7f;
            7'd77:  g = 40'h7f_20_18_20_7f;
            7'd78:  g = 40'h7f_04_08_10_7f;
            7'd79:  g = 40'h3e_41_41_41_3e;
            7'd80:  g = 40'h30_48_48_48_7f;
            7'd81:  g = 40'h3d_42_45_41_3e;
            7'd82:  g = 40'h31_4a_4c_48_7f;
            7'd83:  g = 40'h46_49_49_49_31;
            7'd84:  g = 40'h40_40_7f_40_40;
            7'd85:  g = 40'h7e_01_01_01_7e;
            7'd86:  g = 40'h7c_02_01_02_7c;
            7'd87:  g = 40'h7e_01_0e_01_7e;
            7'd88:  g = 40'h63_14_08_14_63;
            7'd89:  g = 40'h70_08_07_08_70;
            7'd90:  g = 40'h61_51_49_45_43;
            7'd91:  g = 40'h00_41_41_7f_00;
            7'd92:  g = 40'h54_34_1f_34_54;
            7'd93:  g = 40'h00_7f_41_41_00;
            7'd94:  g = 40'h10_20_40_20_10;
            7'd95:  g = 40'h01_01_01_01_01;
            7'd96:  g = 40'h00_10_20_40_00;
            7'd97:  g = 40'h0f_15_15_15_02;
            7'd98:  g = 40'h0e_11_11_09_7f;
            7'd99:  g = 40'h02_11_11_11_0e;
            7'd100: g = 40'h7f_09_11_11_0e;
            7'd101: g = 40'h0c_15_15_15_0e;
            7'd102: g = 40'h20_40_48_3f_08;
            7'd103: g = 40'h3e_25_25_25_18;
            7'd104: g = 40'h0f_10_10_08_7f;
            7'd105: g = 40'h00_01_5f_11_00;
            7'd106: g = 40'h00_5e_11_01_02;
            7'd107: g = 40'h00_11_0a_04_7f;
            7'd108: g = 40'h00_01_7f_41_00;
            7'd109: g = 40'h0f_10_0c_10_1f;
            7'd110: g = 40'h0f_10_10_08_1f;
            7'd111: g = 40'h0e_11_11_11_0e;
            7'd112: g = 40'h08_14_14_14_1f;
            7'd113: g = 40'h1f_0c_14_14_08;
            7'd114: g = 40'h08_10_10_08_1f;
            7'd115: g = 40'h02_15_15_15_09;
            7'd116: g = 40'h02_01_11_7e_10;
            7'd117: g = 40'h1f_02_01_01_1e;
            7'd118: g = 40'h1c_02_01_02_1c;
            7'd119: g = 40'h1e_01_0e_01_1e;
            7'd120: g = 40'h11_0a_04_0a_11;
            7'd121: g = 40'h1e_05_05_05_18;
            7'd122: g = 40'h11_19_15_13_11;
            7'd123: g = 40'h00_41_36_08_00;
            7'd124: g = 40'h00_00_7f_00_00;
            7'd125: g = 40'h00_08_36_41_00;
            7'd126: g = 40'h08_04_04_08_04;
            default: g = '0;
        endcase
        return g;
    endfunction

    // Bit 0 is sent first: column 4 row 0, up to column 0 row 6.
    function automatic t_pattern glyph_to_stream(input t_glyph g);
        t_pattern s;
        s = '0;
        for (int j = 0; j < GLYPH_COLS; j++) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                s[j*GLYPH_ROWS + r] = g[j*COL_W + r];
            end
        end
        return s;
    endfunction

    // Control words go out MSB first, so the word is reversed into the low bits.
    function automatic t_pattern ctrl_to_stream(input logic [VALUE_W-1:0] w);
        t_pattern s;
        s = '0;
        for (int i = 0; i < CTRL_BITS; i++) begin
            s[i] = w[CTRL_BITS-1-i];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> design/dmfs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dmfs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [dmfs_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dmfs_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic register_select;
    logic frame_end;
    logic last;

    modport source (output valid, output serial_bit, output register_select,
                    output frame_end, output last, input ready);
    modport sink   (input valid, input serial_bit, input register_select,
                    input frame_end, input last, output ready);
endinterface

`default_nettype wire

>>> design/dot_matrix_font_serializer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Payload                                      | Beat
// ----------+-----+----------------------------------------------+---------------------------
// i_item    | in  | mode, value[7:0]                             | one character or control word
// o_bit     | out | serial_bit, register_select, frame_end, last | one serial clock of data
//
// A character produces 35 output beats and a control word 8, one beat per cycle.
// The shift register streams without gaps: the next item waits, already looked up,
// in a one-entry holding stage, so a new item is taken while the current one is
// still being shifted out. Throughput is set by the output shifter, one bit a cycle.
// Reset (i_rst_n low, synchronous) empties both stages and clears the character position.
// A stall on o_bit freezes the shifter; the input stalls only once the holding stage is full.

module dot_matrix_font_serializer_core #(
    parameter int CHARS_PER_FRAME = dmfs_pkg::CHARS_PER_FRAME_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    dmfs_in_if.sink        i_item,
    dmfs_out_if.source     o_bit
);
    import dmfs_pkg::*;

    // Holding stage: the glyph ROM is read synchronously into this register when the
    // item is accepted, together with its framing flags.
    logic     r_pend_valid;
    t_pattern r_pend_pat;
    logic     r_pend_rs;
    logic     r_pend_fe;
    t_count   r_pend_cnt;

    // Output shifter. r_cnt counts the beats still to follow the current one.
    logic     r_busy;
    t_pattern r_sh;
    logic     r_rs;
    logic     r_fe;
    t_count   r_cnt;

    // Number of characters already loaded in the current frame.
    t_pos     r_pos;
    t_pos     n_pos;

    logic           w_in_acc;
    logic           w_out_acc;
    logic           w_sh_done;
    logic           w_load;
    logic [POS_W:0] w_pos_inc;
    logic           w_ends;
    t_glyph         w_glyph;

    always_comb begin
        w_in_acc  = i_item.valid && i_item.ready;
        w_out_acc = o_bit.valid && o_bit.ready;
        // The shifter is free when it is empty or its final beat leaves this cycle.
        w_sh_done = !r_busy || (w_out_acc && (r_cnt == '0));
        w_load    = w_sh_done && r_pend_valid;
        w_pos_inc = {1'b0, r_pos} + (POS_W+1)'(1);
        // A character ends the frame when it fills the last slot, or when the
        // position already sits at or beyond it.
        w_ends    = w_pos_inc >= (POS_W+1)'(CHARS_PER_FRAME);
        // Codes with the top bit set have no glyph and show blank.
        w_glyph   = i_item.value[VALUE_W-1] ? '0 : font_glyph(i_item.value[VALUE_W-2:0]);
        if (i_item.mode == MODE_CTRL || w_ends) begin
            n_pos = '0;
        end else begin
            n_pos = w_pos_inc[POS_W-1:0];
        end
    end

    assign i_item.ready          = !r_pend_valid || w_load;
    assign o_bit.valid           = r_busy;
    assign o_bit.serial_bit      = r_sh[0];
    assign o_bit.register_select = r_rs;
    assign o_bit.last            = (r_cnt == '0);
    assign o_bit.frame_end       = r_fe && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_pos        <= '0;
        end else begin
            if (w_in_acc) begin
                r_pend_valid <= 1'b1;
                r_pos        <= n_pos;
            end else if (w_load) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_sh_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Registered ROM read and payload capture; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (i_item.mode == MODE_CTRL) begin
                r_pend_pat <= ctrl_to_stream(i_item.value);
                r_pend_rs  <= 1'b1;
                r_pend_fe  <= 1'b1;
                r_pend_cnt <= CNT_W'(CTRL_BITS - 1);
            end else begin
                r_pend_pat <= glyph_to_stream(w_glyph);
                r_pend_rs  <= 1'b0;
                r_pend_fe  <= w_ends;
                r_pend_cnt <= CNT_W'(PAT_W - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sh  <= r_pend_pat;
            r_rs  <= r_pend_rs;
            r_fe  <= r_pend_fe;
            r_cnt <= r_pend_cnt;
        end else if (w_out_acc) begin
            r_sh  <= r_sh >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // The position never reaches the frame size.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_pos) < CHARS_PER_FRAME) || (r_pos == '0))
        else $error("character position outside the frame");

    // A control word always restarts the character position.
    a_ctrl_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_item.mode == MODE_CTRL) |=> (r_pos == '0))
        else $error("control word did not reset the character position");

    // Frame end only on the final beat of an item.
    a_fe_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bit.valid && o_bit.frame_end) |-> o_bit.last)
        else $error("frame end on a beat that is not last");

    // Inside an item, the stream continues with the same register select.
    a_item_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_bit.last) |=> (o_bit.valid && $stable(o_bit.register_select)))
        else $error("item stream broken before its last beat");

    // A waiting item is not dropped while the shifter is still busy.
    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && !w_load) |=> r_pend_valid)
        else $error("pending item lost");

endmodule

`default_nettype wire

>>> dv/dot_matrix_font_serializer_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the dot-matrix font serializer. A queue of load items
// (characters and control words) is built up front and fed by a falling-edge
// driver with random idle gaps. A rising-edge monitor predicts the serial beats of
// every accepted item and compares each output beat against the oldest prediction.
// The receiving side stalls at random, with occasional long stalls and stall-free stretches.
module dot_matrix_font_serializer_core_tb;
    import dmfs_pkg::*;

    localparam int FRAME_CHARS  = CHARS_PER_FRAME_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
    } load_item_t;

    typedef struct packed {
        logic serial_bit;
        logic reg_sel;
        logic frame_end;
        logic last;
    } serial_beat_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dmfs_in_if  item_if ();
    dmfs_out_if bit_if ();

    dot_matrix_font_serializer_core #(
        .CHARS_PER_FRAME(FRAME_CHARS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_bit   (bit_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    load_item_t   load_queue [$];
    serial_beat_t bits_due [$];

    // Predicted display state: characters already loaded in the current frame.
    logic [POS_W-1:0] frame_slot = '0;

    logic item_taken = 1'b0;
    int   in_gap     = 0;
    int   out_stall  = 0;
    bit   in_burst   = 1'b0;
    bit   out_burst  = 1'b0;

    int errors       = 0;
    int beats_seen   = 0;
    int chars_loaded = 0;
    int blank_chars  = 0;
    int ctrl_words   = 0;
    int frames_full  = 0;

    // Font columns, column 0 in the top byte down to column 4 in the bottom byte.
    // Each byte holds rows 0..6 in bits 0..6.
    function automatic logic [39:0] glyph_columns(input logic [6:0] code);
        logic [39:0] g;
        case (code)
            7'd33:  g = 40'h00007b0000;
            7'd34:  g = 40'h0070007000;
            7'd35:  g = 40'h147f147f14;
            7'd36:  g = 40'h242a7f2a12;
            7'd37:  g = 40'h2313086462;
            7'd38:  g = 40'h0522554936;
            7'd39:  g = 40'h0000605000;
            7'd40:  g = 40'h0041221c00;
            7'd41:  g = 40'h001c224100;
            7'd42:  g = 40'h14083e0814;
            7'd43:  g = 40'h08083e0808;
            7'd44:  g = 40'h0000060500;
            7'd45:  g = 40'h0808080808;
            7'd46:  g = 40'h0000030300;
            7'd47:  g = 40'h2010080402;
            7'd48:  g = 40'h3e5149453e;
            7'd49:  g = 40'h00017f2100;
            7'd50:  g = 40'h3149454321;
            7'd51:  g = 40'h4669514142;
            7'd52:  g = 40'h047f24140c;
            7'd53:  g = 40'h4e51515172;
            7'd54:  g = 40'h064949291e;
            7'd55:  g = 40'h7048474040;
            7'd56:  g = 40'h3649494936;
            7'd57:  g = 40'h3c4a494930;
            7'd58:  g = 40'h0000363600;
            7'd59:  g = 40'h0000363500;
            7'd60:  g = 40'h0041221408;
            7'd61:  g = 40'h1414141414;
            7'd62:  g = 40'h0814224100;
            7'd63:  g = 40'h3048444520;
            7'd64:  g = 40'h324979413e;
            7'd65:  g = 40'h3f4444443f;
            7'd66:  g = 40'h364949497f;
            7'd67:  g = 40'h224141413e;
            7'd68:  g = 40'h1c2241417f;
            7'd69:  g = 40'h414949497f;
            7'd70:  g = 40'h404848487f;
            7'd71:  g = 40'h2f4949413e;
            7'd72:  g = 40'h7f0808087f;
            7'd73:  g = 40'h00417f4100;
            7'd74:  g = 40'h407e410102;
            7'd75:  g = 40'h412214087f;
            7'd76:  g = 40'h010101017f;
            7'd77:  g = 40'h7f2018207f;
            7'd78:  g = 40'h7f0408107f;
            7'd79:  g = 40'h3e4141413e;
            7'd80:  g = 40'h304848487f;
            7'd81:  g = 40'h3d4245413e;
            7'd82:  g = 40'h314a4c487f;
            7'd83:  g = 40'h4649494931;
            7'd84:  g = 40'h40407f4040;
            7'd85:  g = 40'h7e0101017e;
            7'd86:  g = 40'h7c0201027c;
            7'd87:  g = 40'h7e010e017e;
            7'd88:  g = 40'h6314081463;
            7'd89:  g = 40'h7008070870;
            7'd90:  g = 40'h6151494543;
            7'd91:  g = 40'h0041417f00;
            7'd92:  g = 40'h54341f3454;
            7'd93:  g = 40'h007f414100;
            7'd94:  g = 40'h1020402010;
            7'd95:  g = 40'h0101010101;
            7'd96:  g = 40'h0010204000;
            7'd97:  g = 40'h0f15151502;
            7'd98:  g = 40'h0e1111097f;
            7'd99:  g = 40'h021111110e;
            7'd100: g = 40'h7f0911110e;
            7'd101: g = 40'h0c1515150e;
            7'd102: g = 40'h2040483f08;
            7'd103: g = 40'h3e25252518;
            7'd104: g = 40'h0f1010087f;
            7'd105: g = 40'h00015f1100;
            7'd106: g = 40'h005e110102;
            7'd107: g = 40'h00110a047f;
            7'd108: g = 40'h00017f4100;
            7'd109: g = 40'h0f100c101f;
            7'd110: g = 40'h0f1010081f;
            7'd111: g = 40'h0e1111110e;
            7'd112: g = 40'h081414141f;
            7'd113: g = 40'h1f0c141408;
            7'd114: g = 40'h081010081f;
            7'd115: g = 40'h0215151509;
            7'd116: g = 40'h0201117e10;
            7'd117: g = 40'h1f0201011e;
            7'd118: g = 40'h1c0201021c;
            7'd119: g = 40'h1e010e011e;
            7'd120: g = 40'h110a040a11;
            7'd121: g = 40'h1e05050518;
            7'd122: g = 40'h1119151311;
            7'd123: g = 40'h0041360800;
            7'd124: g = 40'h00007f0000;
            7'd125: g = 40'h0008364100;
            7'd126: g = 40'h0804040804;
            default: g = '0;
        endcase
        return g;
    endfunction

    // Appends the serial beats that one accepted item produces and advances
    // the predicted frame position.
    task automatic predict_serial_beats(input load_item_t it);
        logic [39:0]  cols;
        logic [7:0]   pat;
        logic         closes;
        logic         fin;
        serial_beat_t b;
        if (it.mode == MODE_CTRL) begin
            // Control words go out MSB first and always close their own frame.
            for (int i = 0; i < 8; i++) begin
                b.serial_bit = it.value[7 - i];
                b.reg_sel    = 1'b1;
                b.frame_end  = (i == 7);
                b.last       = (i == 7);
                bits_due.push_back(b);
            end
            frame_slot = '0;
            ctrl_words++;
        end else begin
            closes = (int'(frame_slot) + 1 >= FRAME_CHARS);
            // Codes with the top bit set have no glyph and show blank.
            cols = it.value[7] ? 40'h0 : glyph_columns(it.value[6:0]);
            for (int col = GLYPH_COLS - 1; col >= 0; col--) begin
                pat = cols[(4 - col) * 8 +: 8];
                for (int row = 0; row < GLYPH_ROWS; row++) begin
                    fin = (col == 0) && (row == GLYPH_ROWS - 1);
                    b.serial_bit = pat[row];
                    b.reg_sel    = 1'b0;
                    b.frame_end  = fin && closes;
                    b.last       = fin;
                    bits_due.push_back(b);
                end
            end
            if (closes) begin
                frame_slot = '0;
                frames_full++;
            end else begin
                frame_slot = frame_slot + 1'b1;
            end
            chars_loaded++;
            if (it.value[7]) begin
                blank_chars++;
            end
        end
    endtask

    task automatic report_error(input string msg);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic add_item(input logic mode, input logic [VALUE_W-1:0] value);
        load_item_t it;
        it.mode  = mode;
        it.value = value;
        load_queue.push_back(it);
    endtask

    // Mostly short idles, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Input acceptance is predicted before the output is checked. No beat leaves in the
    // same cycle as its item is taken, as the item passes the holding stage first.
    always @(posedge i_clk) begin : beat_monitor
        load_item_t   it;
        serial_beat_t got;
        serial_beat_t want;
        item_taken = i_rst_n && item_if.valid && item_if.ready;
        if (item_taken) begin
            it.mode  = item_if.mode;
            it.value = item_if.value;
            predict_serial_beats(it);
        end
        if (i_rst_n && bit_if.valid && bit_if.ready) begin
            got.serial_bit = bit_if.serial_bit;
            got.reg_sel    = bit_if.register_select;
            got.frame_end  = bit_if.frame_end;
            got.last       = bit_if.last;
            beats_seen++;
            if (bits_due.size() == 0) begin
                report_error($sformatf("unexpected beat bit=%b rs=%b fe=%b last=%b",
                    got.serial_bit, got.reg_sel, got.frame_end, got.last));
            end else begin
                want = bits_due.pop_front();
                if (got !== want) begin
                    report_error($sformatf(
                        "beat %0d: expected bit=%b rs=%b fe=%b last=%b, got bit=%b rs=%b fe=%b last=%b",
                        beats_seen, want.serial_bit, want.reg_sel, want.frame_end, want.last,
                        got.serial_bit, got.reg_sel, got.frame_end, got.last));
                end
            end
        end
    end

    // The item stays on the bus until a rising edge takes it; the next one follows
    // at once or after a random gap, during which the payload carries noise.
    always @(negedge i_clk) begin : item_driver
        load_item_t nxt;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (item_if.valid && !item_taken) begin
            // Holding the current item.
        end else if (in_gap > 0) begin
            item_if.valid <= 1'b0;
            item_if.mode  <= 1'($urandom_range(0, 1));
            item_if.value <= 8'($urandom_range(0, 255));
            in_gap--;
        end else if (load_queue.size() != 0) begin
            nxt = load_queue.pop_front();
            item_if.valid <= 1'b1;
            item_if.mode  <= nxt.mode;
            item_if.value <= nxt.value;
            if ($urandom_range(0, 49) == 0) begin
                in_burst = !in_burst;
            end
            in_gap = (in_burst || $urandom_range(0, 99) < 55) ? 0 : pick_idle_len();
        end else begin
            item_if.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : beat_sink
        if (out_stall > 0) begin
            bit_if.ready <= 1'b0;
            out_stall--;
        end else if (!out_burst && $urandom_range(0, 99) < 10) begin
            bit_if.ready <= 1'b0;
            out_stall = pick_idle_len() - 1;
        end else begin
            bit_if.ready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0) begin
            out_burst = !out_burst;
        end
    end

    initial begin : timeout_guard
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d items unsent and %0d beats outstanding",
            LIMIT_CYCLES, load_queue.size(), bits_due.size());
        $display("FAIL dot_matrix_font_serializer_core");
        $finish;
    end

    initial begin : stimulus
        int run_len;
        int made;
        item_if.valid = 1'b0;
        item_if.mode  = MODE_CHAR;
        item_if.value = '0;
        bit_if.ready  = 1'b0;

        // Directed: control word extremes, blank and edge codes, a control word
        // that cuts a frame short, and a full frame of characters.
        add_item(MODE_CTRL, 8'hff);
        add_item(MODE_CTRL, 8'h00);
        add_item(MODE_CHAR, 8'h30);
        add_item(MODE_CHAR, 8'h41);
        add_item(MODE_CHAR, 8'h7e);
        add_item(MODE_CTRL, 8'h80);
        add_item(MODE_CHAR, 8'h21);
        add_item(MODE_CHAR, 8'h7f);
        add_item(MODE_CHAR, 8'h80);
        add_item(MODE_CHAR, 8'hff);
        add_item(MODE_CHAR, 8'h23);
        add_item(MODE_CHAR, 8'h40);
        add_item(MODE_CHAR, 8'h57);
        add_item(MODE_CHAR, 8'h5a);
        add_item(MODE_CHAR, 8'h00);
        add_item(MODE_CHAR, 8'h1f);
        add_item(MODE_CHAR, 8'h20);
        add_item(MODE_CTRL, 8'h01);
        add_item(MODE_CTRL, 8'h55);
        add_item(MODE_CHAR, 8'h26);
        add_item(MODE_CTRL, 8'haa);

        // Random: runs of characters, often a whole frame, usually closed by a
        // control word. Most codes are printable, the rest span the full byte.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            run_len = ($urandom_range(0, 3) == 0) ? FRAME_CHARS : $urandom_range(1, 12);
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 99) < 80) begin
                    add_item(MODE_CHAR, 8'($urandom_range(32, 126)));
                end else begin
                    add_item(MODE_CHAR, 8'($urandom_range(0, 255)));
                end
                made++;
            end
            if ($urandom_range(0, 2) != 0) begin
                add_item(MODE_CTRL, 8'($urandom_range(0, 255)));
                made++;
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (load_queue.size() != 0 || item_if.valid || bits_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Loaded %0d characters (%0d blank codes) and %0d control words; %0d frames filled.",
            chars_loaded, blank_chars, ctrl_words, frames_full);
        $display("Checked %0d serial beats, %0d mismatches.", beats_seen, errors);
        if (errors == 0) begin
            $display("PASS dot_matrix_font_serializer_core");
        end else begin
            $display("FAIL dot_matrix_font_serializer_core");
        end
        $finish;
    end

endmodule
